// File: rtl/rmst_pkg.sv
// ----------------------------------------------------------------------------
// rmst_pkg: shared types and constants of the range-minimum tree
// Field widths, operation codes, sequencer states and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package rmst_pkg;

    localparam int MAX_LEAVES_DEF = 1024;

    localparam int POS_W = 11;
    localparam int VAL_W = 64;

    localparam logic [POS_W-1:0] LEAF_COUNT_RESET = 11'd1024;

    localparam logic signed [VAL_W-1:0] SENTINEL_MIN = 64'sd1000000000000000000;
    localparam logic signed [VAL_W-1:0] VAL_MAX      = 64'sh7FFF_FFFF_FFFF_FFFF;

    // operation selector carried in tuser
    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UP_READ,
        S_UP_WRITE,
        S_Q_TEST,
        S_Q_A,
        S_Q_B,
        S_DONE
    } t_state;

    typedef struct packed {
        logic signed [VAL_W-1:0] minimum;
        logic                    empty_range;
        logic                    bad_range;
    } t_result;

    function automatic logic signed [VAL_W-1:0] min_s64(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

endpackage

`default_nettype wire

// File: rtl/rmst_node_ram.sv
// ----------------------------------------------------------------------------
// rmst_node_ram: tree node storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rmst_node_ram #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_we,
    input  wire logic [AW-1:0]                       i_waddr,
    input  wire logic signed [rmst_pkg::VAL_W-1:0]   i_wdata,
    input  wire logic [AW-1:0]                       i_raddr,
    output logic signed [rmst_pkg::VAL_W-1:0]        o_rdata
);
    import rmst_pkg::*;

    logic signed [VAL_W-1:0] mem [DEPTH];
    logic signed [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/rmst_ctrl.sv
// ----------------------------------------------------------------------------
// rmst_ctrl: sequencer of the range-minimum tree
// Clears the node store after reset, walks ancestors on an update and the
// bottom-up span on a query, with one shared signed compare.
// ----------------------------------------------------------------------------
`default_nettype none

module rmst_ctrl #(
    parameter int MAX_LEAVES = 1024,
    parameter int DEPTH      = 2 * MAX_LEAVES,
    parameter int AW         = $clog2(DEPTH)
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic                                i_func,
    input  wire logic [rmst_pkg::POS_W-1:0]          i_left,
    input  wire logic [rmst_pkg::POS_W-1:0]          i_right,
    input  wire logic signed [rmst_pkg::VAL_W-1:0]   i_value,
    input  wire logic [rmst_pkg::POS_W-1:0]          i_leaf_count,
    output logic                                     o_res_valid,
    input  wire logic                                i_res_take,
    output rmst_pkg::t_result                        o_res,
    output logic                                     o_ram_we,
    output logic [AW-1:0]                            o_ram_waddr,
    output logic signed [rmst_pkg::VAL_W-1:0]        o_ram_wdata,
    output logic [AW-1:0]                            o_ram_raddr,
    input  wire logic signed [rmst_pkg::VAL_W-1:0]   i_ram_rdata
);
    import rmst_pkg::*;

    // node index with room for DEPTH itself
    localparam int IW = AW + 1;
    localparam int CW = (POS_W > $clog2(MAX_LEAVES + 1)) ? POS_W : $clog2(MAX_LEAVES + 1);

    t_state                  r_state, n_state;
    logic [AW-1:0]           r_clr, n_clr;
    logic [IW-1:0]           r_a, n_a;
    logic [IW-1:0]           r_b, n_b;
    logic signed [VAL_W-1:0] r_acc, n_acc;
    logic                    r_empty, n_empty;
    logic                    r_bad, n_bad;

    logic [CW-1:0]           w_cnt;
    logic [CW-1:0]           w_left;
    logic [CW-1:0]           w_right;
    logic                    w_empty;
    logic                    w_bad;
    logic                    w_pos_ok;
    logic [IW-1:0]           w_leaf_a;
    logic [IW-1:0]           w_leaf_b;
    logic [IW-1:0]           w_a_inc;
    logic [IW-1:0]           w_b_dec;
    logic [IW-1:0]           w_parent;
    logic signed [VAL_W-1:0] w_min;

    assign w_cnt    = (CW'(i_leaf_count) > CW'(MAX_LEAVES)) ? CW'(MAX_LEAVES)
                                                           : CW'(i_leaf_count);
    assign w_left   = CW'(i_left);
    assign w_right  = CW'(i_right);
    assign w_empty  = w_left > w_right;
    assign w_pos_ok = (w_left != '0) && (w_left <= w_cnt);
    assign w_bad    = !w_pos_ok || (w_right == '0) || (w_right > w_cnt);
    assign w_leaf_a = IW'(MAX_LEAVES) + IW'(i_left) - IW'(1);
    assign w_leaf_b = IW'(MAX_LEAVES) + IW'(i_right);
    assign w_a_inc  = r_a + IW'(1);
    assign w_b_dec  = r_b - IW'(1);
    assign w_parent = r_a >> 1;

    // the one compare unit, shared by every walk step
    assign w_min = min_s64(r_acc, i_ram_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a     <= n_a;
        r_b     <= n_b;
        r_acc   <= n_acc;
        r_empty <= n_empty;
        r_bad   <= n_bad;
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_a         = r_a;
        n_b         = r_b;
        n_acc       = r_acc;
        n_empty     = r_empty;
        n_bad       = r_bad;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_a[AW-1:0];
        o_ram_wdata = r_acc;
        o_ram_raddr = r_a[AW-1:0];

        unique case (r_state)
            S_CLEAR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_clr;
                o_ram_wdata = '0;
                n_clr       = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_func == FUNC_UPDATE) begin
                        // out-of-range positions are dropped silently
                        if (w_pos_ok) begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = w_leaf_a[AW-1:0];
                            o_ram_wdata = i_value;
                            n_a         = w_leaf_a;
                            n_acc       = i_value;
                            n_state     = S_UP_READ;
                        end
                    end else begin
                        n_empty = w_empty;
                        n_bad   = w_bad;
                        if (w_empty || w_bad) begin
                            n_acc   = SENTINEL_MIN;
                            n_state = S_DONE;
                        end else begin
                            n_a     = w_leaf_a;
                            n_b     = w_leaf_b;
                            n_acc   = VAL_MAX;
                            n_state = S_Q_TEST;
                        end
                    end
                end
            end
            S_UP_READ: begin
                // fetch the sibling of the node just written
                o_ram_raddr = r_a[AW-1:0] ^ AW'(1);
                n_state     = S_UP_WRITE;
            end
            S_UP_WRITE: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = w_parent[AW-1:0];
                o_ram_wdata = w_min;
                n_acc       = w_min;
                n_a         = w_parent;
                n_state     = (w_parent == IW'(1)) ? S_IDLE : S_UP_READ;
            end
            S_Q_TEST: begin
                if (r_a >= r_b) begin
                    n_state = S_DONE;
                end else if (r_a[0]) begin
                    o_ram_raddr = r_a[AW-1:0];
                    n_state     = S_Q_A;
                end else if (r_b[0]) begin
                    o_ram_raddr = w_b_dec[AW-1:0];
                    n_b         = w_b_dec;
                    n_state     = S_Q_B;
                end else begin
                    n_a = r_a >> 1;
                    n_b = r_b >> 1;
                end
            end
            S_Q_A: begin
                n_acc = w_min;
                if (r_b[0]) begin
                    o_ram_raddr = w_b_dec[AW-1:0];
                    n_b         = w_b_dec;
                    n_a         = w_a_inc;
                    n_state     = S_Q_B;
                end else begin
                    n_a     = w_a_inc >> 1;
                    n_b     = r_b >> 1;
                    n_state = S_Q_TEST;
                end
            end
            S_Q_B: begin
                n_acc   = w_min;
                n_a     = r_a >> 1;
                n_b     = r_b >> 1;
                n_state = S_Q_TEST;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res.minimum     = r_acc;
    assign o_res.empty_range = r_empty;
    assign o_res.bad_range   = r_bad;

endmodule

`default_nettype wire

// File: rtl/range_min_segment_tree.sv
// ----------------------------------------------------------------------------
// range_min_segment_tree: range-minimum tree with point updates
// Keeps 2*MAX_LEAVES signed 64-bit nodes and answers inclusive range minima.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one operation per transaction: tuser selects a point
//   update (0) or a range query (1), tdata holds position/left end, right
//   end and the new value. Updates give no output transaction; each query
//   gives one m_axis transaction with the minimum in tdata and the empty and
//   bad flags in tuser. Empty or bad ranges return 1e18.
//   leaf_count is written through i_cfg_wr_en/i_cfg_wr_data while idle.
// Operation (L = log2(MAX_LEAVES) levels, 10 by default):
//   update: one leaf write, then one sibling read and one parent write per level
//   query: up to two node reads per level
//   out-of-range update or flagged query: no node walk
//   all node reads go through the single read port of the node store
// Reset: clears the node store, one node per cycle, all 2*MAX_LEAVES nodes
//   (2048 by default), while s_axis_tready stays low.
// Stall: a finished result sits in the output register; a further query
//   result waits in the sequencer until that register is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module range_min_segment_tree #(
    parameter int MAX_LEAVES = rmst_pkg::MAX_LEAVES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // [10:0] left_or_position, [21:11] right_end, [85:22] new_value, [87:86] zero
    input  wire logic [87:0]   s_axis_tdata,
    // [0] func
    input  wire logic [0:0]    s_axis_tuser,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // [63:0] minimum
    output logic [63:0]        m_axis_tdata,
    // [0] empty_range, [1] bad_range
    output logic [1:0]         m_axis_tuser,
    input  wire logic          i_cfg_wr_en,
    input  wire logic [10:0]   i_cfg_wr_data
);
    import rmst_pkg::*;

    localparam int DEPTH = 2 * MAX_LEAVES;
    localparam int AW    = $clog2(DEPTH);

    logic [POS_W-1:0]        r_leaf_count;
    logic                    r_out_valid;
    t_result                 r_out;

    logic                    w_res_valid;
    logic                    w_res_take;
    t_result                 w_res;
    logic                    w_ram_we;
    logic [AW-1:0]           w_ram_waddr;
    logic signed [VAL_W-1:0] w_ram_wdata;
    logic [AW-1:0]           w_ram_raddr;
    logic signed [VAL_W-1:0] w_ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leaf_count <= LEAF_COUNT_RESET;
        end else if (i_cfg_wr_en) begin
            r_leaf_count <= i_cfg_wr_data;
        end
    end

    rmst_ctrl #(
        .MAX_LEAVES (MAX_LEAVES),
        .DEPTH      (DEPTH),
        .AW         (AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_func       (s_axis_tuser[0]),
        .i_left       (s_axis_tdata[10:0]),
        .i_right      (s_axis_tdata[21:11]),
        .i_value      (s_axis_tdata[85:22]),
        .i_leaf_count (r_leaf_count),
        .o_res_valid  (w_res_valid),
        .i_res_take   (w_res_take),
        .o_res        (w_res),
        .o_ram_we     (w_ram_we),
        .o_ram_waddr  (w_ram_waddr),
        .o_ram_wdata  (w_ram_wdata),
        .o_ram_raddr  (w_ram_raddr),
        .i_ram_rdata  (w_ram_rdata)
    );

    rmst_node_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // output register, refilled in the cycle it drains
    assign w_res_take = w_res_valid && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.minimum;
    assign m_axis_tuser  = {r_out.bad_range, r_out.empty_range};

endmodule

`default_nettype wire

// File: sim/range_min_segment_tree_tb.sv
// ----------------------------------------------------------------------------
// range_min_segment_tree_tb: self-checking bench for the range-minimum tree
// Drives point updates and range queries over the stream port, keeps its own
// array of leaf values to predict every query answer, and compares each
// output transaction field by field. Directed cases cover value extremes,
// empty and bad ranges and leaf_count corners; random phases follow with
// varying backpressure on both sides.
// ----------------------------------------------------------------------------
module range_min_segment_tree_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rmst_pkg::*;

    localparam int LEAVES         = MAX_LEAVES_DEF;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 64'sh8000_0000_0000_0000;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [87:0]        s_axis_tdata  = '0;
    logic [0:0]         s_axis_tuser  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [63:0]        m_axis_tdata;
    logic [1:0]         m_axis_tuser;
    logic               i_cfg_wr_en   = 1'b0;
    logic [POS_W-1:0]   i_cfg_wr_data = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count    = 0;
    int quiet_cycles  = 0;

    // mirror of the leaf values, cleared like the node store
    logic signed [VAL_W-1:0] leaf_value [1:LEAVES];
    logic [POS_W-1:0]        leaf_count_reg = LEAF_COUNT_RESET;
    t_result                 pending_answers [$];

    always #10 i_clk = ~i_clk;

    range_min_segment_tree uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        for (int p = 1; p <= LEAVES; p++) begin
            leaf_value[p] = '0;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic int unsigned active_leaves();
        return (leaf_count_reg > LEAVES) ? LEAVES : leaf_count_reg;
    endfunction

    function automatic t_result range_min_answer(logic [POS_W-1:0] lo, logic [POS_W-1:0] hi);
        t_result                 ans;
        int unsigned             cnt;
        logic signed [VAL_W-1:0] best;
        cnt = active_leaves();
        ans.empty_range = (lo > hi);
        ans.bad_range = (lo < 1) || (lo > cnt) || (hi < 1) || (hi > cnt);
        best = SENTINEL_MIN;
        if (!ans.empty_range && !ans.bad_range) begin
            best = VAL_MAX;
            for (int p = lo; p <= hi; p++) begin
                if (leaf_value[p] < best) begin
                    best = leaf_value[p];
                end
            end
        end
        ans.minimum = best;
        return ans;
    endfunction

    function automatic logic signed [VAL_W-1:0] random_value();
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(5))
                    0: return VAL_MAX;
                    1: return VAL_MIN;
                    2: return 64'sd0;
                    3: return -64'sd1;
                    4: return SENTINEL_MIN;
                    default: return SENTINEL_MIN + 64'sd1;
                endcase
            end
            1, 2: return $signed(64'($urandom_range(2000))) - 64'sd1000;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            fail_count++;
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin : check_answers
        t_result want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_answers.size() == 0) begin
                fail_count++;
                $error("unexpected result transaction, minimum %0d", $signed(m_axis_tdata));
            end else begin
                want = pending_answers.pop_front();
                check_field("minimum", want.minimum, m_axis_tdata);
                check_field("empty_range", 64'(want.empty_range), 64'(m_axis_tuser[0]));
                check_field("bad_range", 64'(want.bad_range), 64'(m_axis_tuser[1]));
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // called at a falling edge; leaves tvalid high after the transaction
    task automatic send_op(logic func, logic [POS_W-1:0] pos_or_lo, logic [POS_W-1:0] hi,
                           logic signed [VAL_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {2'b00, value, hi, pos_or_lo};
        do @(posedge i_clk); while (!s_axis_tready);
        if (func == FUNC_UPDATE) begin
            if (pos_or_lo >= 1 && pos_or_lo <= active_leaves()) begin
                leaf_value[pos_or_lo] = value;
            end
        end else begin
            pending_answers.push_back(range_min_answer(pos_or_lo, hi));
        end
        @(negedge i_clk);
    endtask

    // stop sending until every answer is back, then let a trailing update finish
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_leaf_count(logic [POS_W-1:0] cnt);
        wait_idle();
        i_cfg_wr_en    <= 1'b1;
        i_cfg_wr_data  <= cnt;
        leaf_count_reg = cnt;
        @(negedge i_clk);
        i_cfg_wr_en    <= 1'b0;
    endtask

    task automatic test_after_reset();
        send_op(FUNC_QUERY, 11'd1, 11'd1024, '0);
        send_op(FUNC_QUERY, 11'd512, 11'd512, '0);
    endtask

    task automatic test_value_extremes();
        send_op(FUNC_UPDATE, 11'd1, '0, -64'sd1);
        send_op(FUNC_UPDATE, 11'd1024, 11'd2047, VAL_MIN);
        send_op(FUNC_UPDATE, 11'd512, '0, VAL_MAX);
        send_op(FUNC_QUERY, 11'd1, 11'd1024, '0);
        send_op(FUNC_QUERY, 11'd1, 11'd1023, '0);
        send_op(FUNC_QUERY, 11'd512, 11'd512, '1);
        // out-of-range updates must leave the tree untouched
        send_op(FUNC_UPDATE, 11'd0, '0, -64'sd5);
        send_op(FUNC_UPDATE, 11'd2047, '0, VAL_MIN + 64'sd1);
        send_op(FUNC_QUERY, 11'd1024, 11'd1024, '0);
    endtask

    task automatic test_range_flags();
        // empty span hides stored values below the sentinel
        send_op(FUNC_QUERY, 11'd10, 11'd9, '0);
        send_op(FUNC_QUERY, 11'd0, 11'd5, '0);
        send_op(FUNC_QUERY, 11'd5, 11'd1025, '0);
        send_op(FUNC_QUERY, 11'd2047, 11'd2047, '0);
        send_op(FUNC_QUERY, 11'd2047, 11'd0, '0);
    endtask

    task automatic test_leaf_count();
        write_leaf_count(11'd1);
        send_op(FUNC_QUERY, 11'd1, 11'd2, '0);
        send_op(FUNC_UPDATE, 11'd2, '0, -64'sd7);
        send_op(FUNC_UPDATE, 11'd1, '0, 64'sd5);
        send_op(FUNC_QUERY, 11'd1, 11'd1, '0);
        // zero positions in use: everything is out of range
        write_leaf_count(11'd0);
        send_op(FUNC_UPDATE, 11'd1, '0, -64'sd9);
        send_op(FUNC_QUERY, 11'd1, 11'd1, '0);
        // counts above the tree size clamp to the tree size
        write_leaf_count(11'd2047);
        send_op(FUNC_QUERY, 11'd1, 11'd1024, '0);
        send_op(FUNC_QUERY, 11'd1, 11'd1025, '0);
        write_leaf_count(LEAF_COUNT_RESET);
        send_op(FUNC_QUERY, 11'd2, 11'd1024, '0);
    endtask

    task automatic test_random_ops(int items, int sender_idle, int receiver_idle,
                                   logic [POS_W-1:0] cnt);
        int               done;
        int unsigned      lim;
        int unsigned      kind;
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
        write_leaf_count(cnt);
        send_idle_pct = sender_idle;
        recv_idle_pct = receiver_idle;
        lim = active_leaves();
        done = 0;
        while (done < items) begin
            if ($urandom_range(63) == 0) begin
                wait_idle();
            end
            if ($urandom_range(1) == 0) begin
                if ($urandom_range(9) == 0) begin
                    lo = POS_W'($urandom_range(2047));
                end else begin
                    lo = POS_W'($urandom_range(lim, 1));
                end
                send_op(FUNC_UPDATE, lo, POS_W'($urandom_range(2047)), random_value());
                if (lo >= 1 && lo <= lim) begin
                    done++;
                end
            end else begin
                kind = $urandom_range(9);
                if (kind < 7) begin
                    lo = POS_W'($urandom_range(lim, 1));
                    if (kind < 4) begin
                        hi = lo + POS_W'($urandom_range(7));
                    end else begin
                        hi = lo + POS_W'($urandom_range(lim - lo));
                    end
                    if (hi > lim) begin
                        hi = POS_W'(lim);
                    end
                end else if (kind == 7 && lim >= 2) begin
                    hi = POS_W'($urandom_range(lim - 1, 1));
                    lo = POS_W'($urandom_range(lim, hi + 1));
                end else begin
                    lo = POS_W'($urandom_range(2047));
                    hi = POS_W'($urandom_range(2047));
                end
                send_op(FUNC_QUERY, lo, hi, random_value());
                done++;
            end
        end
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_value_extremes();
        test_range_flags();
        test_leaf_count();

        test_random_ops(400, 20, 60, LEAF_COUNT_RESET);
        test_random_ops(400, 60, 20, POS_W'($urandom_range(16, 2)));
        test_random_ops(400, 0, 0, POS_W'($urandom_range(1024, 100)));

        wait_idle();
        if (fail_count == 0 && pending_answers.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
